// ----- rtl/disk_block_allocator_assert.svh -----
// Assertion macros shared by the disk block allocator RTL.
`ifndef DISK_BLOCK_ALLOCATOR_ASSERT_SVH
`define DISK_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dba_pkg.sv -----
// Types, codes and constants shared by the disk block allocator modules.
package dba_pkg;

    localparam int unsigned DISK_BLOCKS_DEF     = 1024;
    localparam int unsigned MAX_FILE_BLOCKS_DEF = 63;
    localparam int unsigned FILE_W              = 6;
    localparam int unsigned CFG_FIELD_W         = 11;
    localparam int unsigned PADDR_W             = 3;
    localparam int unsigned PDATA_W             = 32;

    localparam logic [PADDR_W-3:0] REG_DISK_BLOCKS_IN_USE = '0;

    typedef enum logic [1:0] {
        KIND_MARK    = 2'd0,
        KIND_CONTIG  = 2'd1,
        KIND_LINKED  = 2'd2,
        KIND_INDEXED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_NOSPACE = 2'd2,
        STAT_NORUN   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EMIT_FAIL,
        EMIT_CUR,
        EMIT_PREV_LINK,
        EMIT_PREV_END
    } t_emit_sel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_RECOUNT,
        S_IDLE,
        S_CHECK,
        S_MARK,
        S_SCAN,
        S_FILL,
        S_TAIL
    } t_state;

    typedef struct packed {
        logic      item_load;
        logic      scan_start;
        logic      cur_bn;
        logic      cur_run;
        logic      cur_inc;
        logic      run_update;
        logic      mem_wr;
        logic      mem_wr_val;
        logic      free_load_cfg;
        logic      free_zero;
        logic      free_inc;
        logic      free_dec;
        logic      found_inc;
        logic      prev_load;
        logic      emit;
        t_emit_sel emit_sel;
        t_status   fail_status;
        logic      is_index;
        logic      last;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  cfg_wr;
        logic  bit_occ;
        logic  cur_lt_size;
        logic  bn_oob;
        logic  n_invalid;
        logic  free_lt_need;
        logic  run_done;
        logic  found_last;
        logic  found_zero;
        logic  have_prev;
        logic  clear_done;
        logic  out_free;
    } t_dp_stat;

endpackage

// ----- rtl/disk_block_allocator.sv -----
// Top level of the bitmap disk block allocator: block marking, first-fit contiguous, linked and indexed allocation.
// A mark request is checked, then its block is read and its result issued; a block out of range
// fails at the check. An allocation is checked, then scans up to disk_blocks_in_use blocks, one per
// cycle unless a result waits to be taken, with one result per block, overlapped for linked and indexed.
// Throughput: one transaction at a time, bounded by the single-bit bitmap read port.
// Reset: synchronous, active low; a clearing pass over all DISK_BLOCKS blocks then marks them free.
module disk_block_allocator #(
    parameter int unsigned DISK_BLOCKS     = dba_pkg::DISK_BLOCKS_DEF,
    parameter int unsigned MAX_FILE_BLOCKS = dba_pkg::MAX_FILE_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // APB-style register port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dba_pkg::PADDR_W-1:0]    paddr,
    input  logic [dba_pkg::PDATA_W-1:0]    pwdata,
    output logic [dba_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,

    // Request channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_kind,
    input  logic [$clog2(DISK_BLOCKS)-1:0] i_block_number,
    input  logic [dba_pkg::FILE_W-1:0]     i_file_blocks,

    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [$clog2(DISK_BLOCKS)-1:0] o_granted_block,
    output logic [$clog2(DISK_BLOCKS):0]   o_next_in_chain,
    output logic                           o_is_index_block,
    output logic                           o_last
);

    import dba_pkg::*;

    // The controller and the datapath talk only through these two bundles.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Register writes complete in the access phase with no wait states.
    assign pready = 1'b1;

    // The controller owns the state machine. After reset it sweeps the bitmap clear,
    // then waits in idle. A register write while idle starts a recount of the free
    // blocks over the new range, which holds off new transactions. Each accepted
    // transaction is checked first; mark requests read their block, allocations scan
    // the bitmap from block zero.
    dba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the bitmap RAM, the scan pointer, the run tracker for first
    // fit, the free-block counter and the result register. The result register lets
    // the block keep scanning while a finished result waits to be taken.
    dba_datapath #(
        .DISK_BLOCKS     (DISK_BLOCKS),
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_kind           (i_kind),
        .i_block_number   (i_block_number),
        .i_file_blocks    (i_file_blocks),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_granted_block  (o_granted_block),
        .o_next_in_chain  (o_next_in_chain),
        .o_is_index_block (o_is_index_block),
        .o_last           (o_last)
    );

endmodule

// ----- rtl/dba_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module dba_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/dba_datapath.sv -----
// Datapath: bitmap RAM, scan pointer, counters, register file and result register.
module dba_datapath #(
    parameter int unsigned DISK_BLOCKS     = dba_pkg::DISK_BLOCKS_DEF,
    parameter int unsigned MAX_FILE_BLOCKS = dba_pkg::MAX_FILE_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dba_pkg::t_dp_cmd                 i_cmd,
    output dba_pkg::t_dp_stat                o_stat,
    input  logic [1:0]                       i_kind,
    input  logic [$clog2(DISK_BLOCKS)-1:0]   i_block_number,
    input  logic [dba_pkg::FILE_W-1:0]       i_file_blocks,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dba_pkg::PADDR_W-1:0]      paddr,
    input  logic [dba_pkg::PDATA_W-1:0]      pwdata,
    output logic [dba_pkg::PDATA_W-1:0]      prdata,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [1:0]                       o_status,
    output logic [$clog2(DISK_BLOCKS)-1:0]   o_granted_block,
    output logic [$clog2(DISK_BLOCKS):0]     o_next_in_chain,
    output logic                             o_is_index_block,
    output logic                             o_last
);

    import dba_pkg::*;

    localparam int unsigned AW = $clog2(DISK_BLOCKS);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned VW = (CW > CFG_FIELD_W) ? CW : CFG_FIELD_W;
    localparam int unsigned FW = FILE_W + 1;
    localparam int unsigned MW = (CW > FW) ? CW : FW;

    logic [CW-1:0]     r_size;
    logic [CW-1:0]     r_free,  n_free;
    t_kind             r_kind;
    logic [AW-1:0]     r_bn;
    logic [FILE_W-1:0] r_n;
    logic [CW-1:0]     r_cur,   n_cur;
    logic [CW-1:0]     r_run_start;
    logic [FILE_W-1:0] r_run_len;
    logic [FW-1:0]     r_found;
    logic [AW-1:0]     r_prev;
    logic              r_have_prev;

    logic              r_out_valid;
    t_status           r_status;
    logic [AW-1:0]     r_granted;
    logic [CW-1:0]     r_next;
    logic              r_index;
    logic              r_last;

    logic              cfg_hit;
    logic              cfg_wr;
    logic [VW-1:0]     cfg_val;
    logic [CW-1:0]     cfg_sat;
    logic [FW-1:0]     need;
    logic [CW-1:0]     run_first;
    logic              rd_bit;
    logic              out_free;

    // Register decode and saturation of the written block count.
    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_DISK_BLOCKS_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign cfg_val = pwdata[VW-1:0];
    assign cfg_sat = (cfg_val > VW'(DISK_BLOCKS)) ? CW'(DISK_BLOCKS) : cfg_val[CW-1:0];
    assign prdata  = cfg_hit ? PDATA_W'(r_size) : '0;

    assign need      = (r_kind == KIND_INDEXED) ? ({1'b0, r_n} + FW'(1)) : {1'b0, r_n};
    assign run_first = (r_run_len == '0) ? r_cur : r_run_start;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        priority if (i_cmd.scan_start) begin
            n_cur = '0;
        end else if (i_cmd.cur_run) begin
            n_cur = run_first;
        end else if (i_cmd.cur_bn) begin
            n_cur = {1'b0, r_bn};
        end else if (i_cmd.cur_inc) begin
            n_cur = r_cur + CW'(1);
        end else begin
            n_cur = r_cur;
        end
    end

    always_comb begin
        priority if (i_cmd.free_load_cfg) begin
            n_free = cfg_wr ? cfg_sat : r_size;
        end else if (i_cmd.free_zero) begin
            n_free = '0;
        end else if (i_cmd.free_inc) begin
            n_free = r_free + CW'(1);
        end else if (i_cmd.free_dec) begin
            n_free = r_free - CW'(1);
        end else begin
            n_free = r_free;
        end
    end

    dba_ram #(
        .WIDTH (1),
        .DEPTH (DISK_BLOCKS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.mem_wr),
        .i_wr_addr (r_cur[AW-1:0]),
        .i_wr_data (i_cmd.mem_wr_val),
        .i_rd_addr (n_cur[AW-1:0]),
        .o_rd_data (rd_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= CW'(DISK_BLOCKS);
            r_free      <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_size <= cfg_sat;
            end
            r_free <= n_free;
            r_cur  <= n_cur;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_kind <= t_kind'(i_kind);
            r_bn   <= i_block_number;
            r_n    <= i_file_blocks;
        end
        if (i_cmd.scan_start) begin
            r_run_len   <= '0;
            r_found     <= '0;
            r_have_prev <= 1'b0;
        end else begin
            if (i_cmd.run_update) begin
                if (rd_bit) begin
                    r_run_len <= '0;
                end else begin
                    if (r_run_len == '0) begin
                        r_run_start <= r_cur;
                    end
                    r_run_len <= r_run_len + FILE_W'(1);
                end
            end
            if (i_cmd.found_inc) begin
                r_found <= r_found + FW'(1);
            end
            if (i_cmd.prev_load) begin
                r_prev      <= r_cur[AW-1:0];
                r_have_prev <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            unique case (i_cmd.emit_sel)
                EMIT_FAIL: begin
                    r_status  <= i_cmd.fail_status;
                    r_granted <= '0;
                    r_next    <= '0;
                    r_index   <= 1'b0;
                    r_last    <= 1'b1;
                end
                EMIT_CUR: begin
                    r_status  <= STAT_OK;
                    r_granted <= r_cur[AW-1:0];
                    r_next    <= '0;
                    r_index   <= i_cmd.is_index;
                    r_last    <= i_cmd.last;
                end
                EMIT_PREV_LINK: begin
                    r_status  <= STAT_OK;
                    r_granted <= r_prev;
                    r_next    <= r_cur;
                    r_index   <= 1'b0;
                    r_last    <= 1'b0;
                end
                EMIT_PREV_END: begin
                    r_status  <= STAT_OK;
                    r_granted <= r_prev;
                    r_next    <= CW'(DISK_BLOCKS);
                    r_index   <= 1'b0;
                    r_last    <= 1'b1;
                end
                default: begin
                    r_status  <= i_cmd.fail_status;
                    r_granted <= '0;
                    r_next    <= '0;
                    r_index   <= 1'b0;
                    r_last    <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_stat              = '0;
        o_stat.kind         = r_kind;
        o_stat.cfg_wr       = cfg_wr;
        o_stat.bit_occ      = rd_bit;
        o_stat.cur_lt_size  = (r_cur < r_size);
        o_stat.bn_oob       = ({1'b0, r_bn} >= r_size);
        o_stat.n_invalid    = (r_n == '0) || (r_n > FILE_W'(MAX_FILE_BLOCKS));
        o_stat.free_lt_need = (MW'(r_free) < MW'(need));
        o_stat.run_done     = !rd_bit && (({1'b0, r_run_len} + FW'(1)) == {1'b0, r_n});
        o_stat.found_last   = ((r_found + FW'(1)) == need);
        o_stat.found_zero   = (r_found == '0);
        o_stat.have_prev    = r_have_prev;
        o_stat.clear_done   = (r_cur == CW'(DISK_BLOCKS - 1));
        o_stat.out_free     = out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_block  = r_granted;
    assign o_next_in_chain  = r_next;
    assign o_is_index_block = r_index;
    assign o_last           = r_last;

endmodule

// ----- rtl/dba_ctrl.sv -----
// Controller: sequences clearing, recount, checks, bitmap scans and result issue.
`include "disk_block_allocator_assert.svh"

module dba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dba_pkg::t_dp_stat i_stat,
    output dba_pkg::t_dp_cmd  o_cmd
);

    import dba_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.mem_wr  = 1'b1;
                o_cmd.cur_inc = 1'b1;
                if (i_stat.clear_done) begin
                    o_cmd.free_load_cfg = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            S_RECOUNT: begin
                if (i_stat.cfg_wr) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.free_zero  = 1'b1;
                end else if (i_stat.cur_lt_size) begin
                    o_cmd.cur_inc  = 1'b1;
                    o_cmd.free_inc = !i_stat.bit_occ;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_in_ready = !i_stat.cfg_wr;
                if (i_stat.cfg_wr) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.free_zero  = 1'b1;
                    n_state          = S_RECOUNT;
                end else if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state         = S_CHECK;
                end
            end

            S_CHECK: begin
                o_cmd.last = 1'b1;
                if (i_stat.kind == KIND_MARK) begin
                    if (!i_stat.bn_oob) begin
                        o_cmd.cur_bn = 1'b1;
                        n_state      = S_MARK;
                    end else if (i_stat.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.fail_status = STAT_INVALID;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.n_invalid || i_stat.free_lt_need) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.fail_status = i_stat.n_invalid ? STAT_INVALID : STAT_NOSPACE;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end

            S_MARK: begin
                o_cmd.last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (i_stat.bit_occ) begin
                        o_cmd.fail_status = STAT_INVALID;
                    end else begin
                        o_cmd.emit_sel   = EMIT_CUR;
                        o_cmd.mem_wr     = 1'b1;
                        o_cmd.mem_wr_val = 1'b1;
                        o_cmd.free_dec   = 1'b1;
                    end
                end
            end

            S_SCAN: begin
                unique case (i_stat.kind)
                    KIND_CONTIG: begin
                        if (!i_stat.cur_lt_size) begin
                            if (i_stat.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.fail_status = STAT_NORUN;
                                o_cmd.last        = 1'b1;
                                n_state           = S_IDLE;
                            end
                        end else if (i_stat.run_done) begin
                            o_cmd.cur_run = 1'b1;
                            n_state       = S_FILL;
                        end else begin
                            o_cmd.run_update = 1'b1;
                            o_cmd.cur_inc    = 1'b1;
                        end
                    end
                    KIND_LINKED: begin
                        if (i_stat.bit_occ) begin
                            o_cmd.cur_inc = 1'b1;
                        end else if (!i_stat.have_prev || i_stat.out_free) begin
                            o_cmd.emit       = i_stat.have_prev;
                            o_cmd.emit_sel   = EMIT_PREV_LINK;
                            o_cmd.prev_load  = 1'b1;
                            o_cmd.mem_wr     = 1'b1;
                            o_cmd.mem_wr_val = 1'b1;
                            o_cmd.free_dec   = 1'b1;
                            o_cmd.found_inc  = 1'b1;
                            o_cmd.cur_inc    = 1'b1;
                            if (i_stat.found_last) begin
                                n_state = S_TAIL;
                            end
                        end
                    end
                    KIND_INDEXED: begin
                        if (i_stat.bit_occ) begin
                            o_cmd.cur_inc = 1'b1;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.emit_sel   = EMIT_CUR;
                            o_cmd.is_index   = i_stat.found_zero;
                            o_cmd.last       = i_stat.found_last;
                            o_cmd.mem_wr     = 1'b1;
                            o_cmd.mem_wr_val = 1'b1;
                            o_cmd.free_dec   = 1'b1;
                            o_cmd.found_inc  = 1'b1;
                            o_cmd.cur_inc    = 1'b1;
                            if (i_stat.found_last) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                    KIND_MARK: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_FILL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_sel   = EMIT_CUR;
                    o_cmd.last       = i_stat.found_last;
                    o_cmd.mem_wr     = 1'b1;
                    o_cmd.mem_wr_val = 1'b1;
                    o_cmd.free_dec   = 1'b1;
                    o_cmd.found_inc  = 1'b1;
                    o_cmd.cur_inc    = 1'b1;
                    if (i_stat.found_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_TAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_PREV_END;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The free count guarantees that a linked or indexed scan never runs off the disk.
    `DBA_ASSERT_IMPLY(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN) && ((i_stat.kind == KIND_LINKED) || (i_stat.kind == KIND_INDEXED)), i_stat.cur_lt_size, "allocation scan passed the managed range")
    // A result is only loaded when the result register can take it.
    `DBA_ASSERT_IMPLY(a_emit_room, i_clk, i_rst_n, o_cmd.emit, i_stat.out_free, "result issued over a waiting result")
    // An accepted transaction always moves on to its checks.
    `DBA_ASSERT_NEXT(a_accept_check, i_clk, i_rst_n, o_in_ready && i_in_valid, r_state == S_CHECK, "accepted transaction not checked")

endmodule
